// ===== rtl/ipq_pkg.sv =====
// ----------------------------------------------------------------------------
// ipq_pkg
// Shared types, constants and helpers of the interrupt priority queue.
// ----------------------------------------------------------------------------
package ipq_pkg;

  // Queue geometry.
  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_BITS  = ADDR_BITS + 1;

  // Entry fields.
  localparam int IRQ_KINDS  = 6;
  localparam int CODE_BITS  = 3;
  localparam int PRIO_BITS  = 4;
  localparam int TICK_BITS  = 32;
  localparam int CNT_BITS   = 32;
  localparam int TABLE_BITS = 24;

  // Priority table after reset: code k has priority k.
  localparam logic [TABLE_BITS-1:0] TABLE_RESET = 24'h543210;

  // Stream word widths.
  localparam int IN_BITS  = 40;
  localparam int OUT_BITS = 112;

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic [PRIO_BITS-1:0] prio;
    logic [TICK_BITS-1:0] tick;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_ENQUEUE     = 2'd0,
    CMD_DEQUEUE     = 2'd1,
    CMD_SET_PANIC   = 2'd2,
    CMD_CLEAR_PANIC = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // Priority of an interrupt code, four bits per code in the table.
  function automatic logic [PRIO_BITS-1:0] prio_lookup(
    input logic [TABLE_BITS-1:0] tbl,
    input logic [CODE_BITS-1:0]  code
  );
    logic [31:0] wide;
    wide = {8'd0, tbl};
    return wide[{code, 2'b00} +: PRIO_BITS];
  endfunction

  // True when entry a must be served strictly before entry b.
  function automatic logic key_less(input entry_t a, input entry_t b);
    return (a.prio < b.prio) || ((a.prio == b.prio) && (a.tick < b.tick));
  endfunction

endpackage

// ===== rtl/interrupt_priority_queue.sv =====
// ----------------------------------------------------------------------------
// interrupt_priority_queue
// Pending-interrupt queue sorted by priority, then by enqueue tick.
// ----------------------------------------------------------------------------
// The queue is kept sorted in a 16-entry memory with registered read data,
// and one item is processed at a time. Panic commands, rejected enqueues,
// enqueues into an empty queue and dequeues on an empty queue go straight to
// the result. Any other enqueue walks from the tail, moving later entries back,
// and a dequeue shifts the remaining entries toward the head, moving one entry
// per cycle through the memory's read and write ports.
// Every item returns one result word; the input stalls while a result is
// held and the next one is ready to leave.
module interrupt_priority_queue
  import ipq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Fields from bit 0: cmd[1:0], irq_code[4:2], tick_stamp[36:5], zero pad.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_BITS-1:0]    s_tdata,
  // Fields from bit 0: status[1:0], served_irq[4:2], served_priority[8:5],
  // served_tick[40:9], pending_count[45:41], handled_total[77:46],
  // dropped_total[109:78], panic_flag[110], zero pad.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_BITS-1:0]   m_tdata,
  input  logic                  cfg_we,
  input  logic [TABLE_BITS-1:0] cfg_wdata
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_INSERT = 6'b000010,
    S_PLACE  = 6'b000100,
    S_HEAD   = 6'b001000,
    S_SHIFT  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t                state;
  logic [COUNT_BITS-1:0] count;
  logic [CNT_BITS-1:0]   handled;
  logic [CNT_BITS-1:0]   dropped;
  logic                  panic;
  logic [TABLE_BITS-1:0] priority_table;
  addr_t                 idx;
  entry_t                new_entry;
  status_t               res_status;
  entry_t                res_served;

  logic                  accept;
  cmd_t                  in_cmd;
  logic [CODE_BITS-1:0]  in_code;
  entry_t                cand;
  addr_t                 count_low;
  logic                  ins_less;

  logic                  mem_we;
  addr_t                 mem_waddr;
  entry_t                mem_wdata;
  addr_t                 mem_raddr;
  entry_t                rd_data;

  // Input word decode.
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign in_cmd    = cmd_t'(s_tdata[1:0]);
  assign in_code   = s_tdata[4:2];
  assign cand.code = in_code;
  assign cand.prio = prio_lookup(priority_table, in_code);
  assign cand.tick = s_tdata[36:5];
  assign count_low = count[ADDR_BITS-1:0];
  assign ins_less  = key_less(new_entry, rd_data);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      priority_table <= TABLE_RESET;
    end else if (cfg_we) begin
      priority_table <= cfg_wdata;
    end
  end

  // Memory port control for the insert and shift walks.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = rd_data;
    mem_raddr = '0;
    case (state)
      S_IDLE: begin
        if (accept && in_cmd == CMD_ENQUEUE && count == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = cand;
        end
        if (in_cmd == CMD_ENQUEUE) begin
          mem_raddr = count_low - addr_t'(1);
        end
      end
      S_INSERT: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = ins_less ? rd_data : new_entry;
        mem_raddr = idx - addr_t'(2);
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = new_entry;
      end
      S_HEAD: begin
        mem_raddr = addr_t'(1);
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx - addr_t'(1);
        mem_wdata = rd_data;
        mem_raddr = idx + addr_t'(1);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  ipq_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // Command sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      handled  <= '0;
      dropped  <= '0;
      panic    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_served <= '0;
            res_status <= ST_OK;
            case (in_cmd)
              CMD_ENQUEUE: begin
                if (count == COUNT_BITS'(QUEUE_DEPTH)) begin
                  dropped    <= dropped + CNT_BITS'(1);
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else if ({1'b0, in_code} >= (CODE_BITS + 1)'(IRQ_KINDS)) begin
                  res_status <= ST_INVALID;
                  state      <= S_DONE;
                end else if (count == '0) begin
                  count <= COUNT_BITS'(1);
                  state <= S_DONE;
                end else begin
                  new_entry <= cand;
                  idx       <= count_low;
                  state     <= S_INSERT;
                end
              end
              CMD_DEQUEUE: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end else begin
                  state <= S_HEAD;
                end
              end
              CMD_SET_PANIC: begin
                panic <= 1'b1;
                state <= S_DONE;
              end
              default: begin
                panic <= 1'b0;
                state <= S_DONE;
              end
            endcase
          end
        end
        // Walk from the tail toward the head, moving later keys back by one.
        S_INSERT: begin
          if (ins_less) begin
            idx <= idx - addr_t'(1);
            if (idx == addr_t'(1)) begin
              state <= S_PLACE;
            end
          end else begin
            count <= count + COUNT_BITS'(1);
            state <= S_DONE;
          end
        end
        S_PLACE: begin
          count <= count + COUNT_BITS'(1);
          state <= S_DONE;
        end
        // Head entry arrives; close the gap if more entries remain.
        S_HEAD: begin
          res_served <= rd_data;
          handled    <= handled + CNT_BITS'(1);
          if (count == COUNT_BITS'(1)) begin
            count <= '0;
            state <= S_DONE;
          end else begin
            idx   <= addr_t'(1);
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if ({1'b0, idx} == count - COUNT_BITS'(1)) begin
            count <= count - COUNT_BITS'(1);
            state <= S_DONE;
          end else begin
            idx <= idx + addr_t'(1);
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, panic, dropped, handled, count, res_served.tick,
                         res_served.prio, res_served.code, res_status};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/ipq_ram.sv =====
// ----------------------------------------------------------------------------
// ipq_ram
// Queue storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ipq_ram
  import ipq_pkg::*;
(
  input  logic   clk,
  input  logic   we,
  input  addr_t  waddr,
  input  entry_t wdata,
  input  addr_t  raddr,
  output entry_t rdata
);

  entry_t mem [QUEUE_DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ipq_checker.sv =====
// ----------------------------------------------------------------------------
// ipq_checker
// Port-level checks of the interrupt priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module ipq_checker
  import ipq_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OUT_BITS-1:0] m_tdata
);

  // A held result word does not change until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // Items are processed one at a time.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in progress");

  // The pending count never exceeds the queue depth.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[45:41] <= COUNT_BITS'(QUEUE_DEPTH))
    else $error("pending count beyond queue depth");

  // A result with a non-ok status reports no served entry.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[40:2] == '0)
    else $error("served fields set on a non-ok result");

  // A drop is reported only with a full queue.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ST_FULL |-> m_tdata[45:41] == COUNT_BITS'(QUEUE_DEPTH))
    else $error("drop reported below full");

endmodule

bind interrupt_priority_queue ipq_checker u_ipq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/sv/tb_interrupt_priority_queue.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_interrupt_priority_queue
// Self-checking bench for the sorted pending-interrupt queue. A scoreboard
// class keeps its own sorted copy of the queue, the counters, the panic flag
// and the priority table. It predicts one result word per accepted command
// word and compares every returned word field by field. The stimulus starts
// with directed corner cases. It then runs random fill and drain bursts under
// several priority tables, with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb_interrupt_priority_queue;
  import ipq_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 6;
  localparam int MAX_IDLE     = 18;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_WORDS  = 230;

  // Command word, fields from bit 0: cmd, irq_code, tick_stamp, zero pad.
  typedef struct packed {
    logic [IN_BITS-CODE_BITS-TICK_BITS-3:0] pad;
    logic [TICK_BITS-1:0]                   tick;
    logic [CODE_BITS-1:0]                   code;
    cmd_t                                   cmd;
  } cmd_word_t;

  // Result word, fields from bit 0 up to the panic flag, then zero pad.
  typedef struct packed {
    logic                 pad;
    logic                 panic;
    logic [CNT_BITS-1:0]  dropped;
    logic [CNT_BITS-1:0]  handled;
    logic [4:0]           pending;
    logic [TICK_BITS-1:0] tick;
    logic [PRIO_BITS-1:0] prio;
    logic [CODE_BITS-1:0] irq;
    status_t              status;
  } result_word_t;

  // Sorted copy of the pending interrupts plus the expected result words.
  class irq_queue_scoreboard;
    typedef struct {
      logic [CODE_BITS-1:0] code;
      logic [PRIO_BITS-1:0] prio;
      logic [TICK_BITS-1:0] tick;
    } pending_irq_t;

    logic [TABLE_BITS-1:0] prio_map;
    pending_irq_t          backlog[$];
    logic [CNT_BITS-1:0]   handled_cnt;
    logic [CNT_BITS-1:0]   dropped_cnt;
    logic                  panic;
    result_word_t          awaited_words[$];
    int                    result_index;
    int                    errors;

    function new();
      prio_map     = TABLE_RESET;
      handled_cnt  = '0;
      dropped_cnt  = '0;
      panic        = 1'b0;
      result_index = 0;
      errors       = 0;
    endfunction

    function void set_table(logic [TABLE_BITS-1:0] value);
      prio_map = value;
    endfunction

    // Apply one accepted command to the shadow queue and queue its result.
    function void note_command(cmd_word_t w);
      result_word_t r;
      pending_irq_t e;
      int           pos;
      int           i;
      r        = '0;
      r.status = ST_OK;
      case (w.cmd)
        CMD_ENQUEUE: begin
          if (backlog.size() >= QUEUE_DEPTH) begin
            dropped_cnt++;
            r.status = ST_FULL;
          end else if (w.code >= IRQ_KINDS) begin
            r.status = ST_INVALID;
          end else begin
            e.code = w.code;
            e.prio = prio_map[4 * w.code +: PRIO_BITS];
            e.tick = w.tick;
            // New entry goes behind every entry with an equal key.
            pos = backlog.size();
            for (i = 0; i < backlog.size(); i++) begin
              if (e.prio < backlog[i].prio ||
                  (e.prio == backlog[i].prio && e.tick < backlog[i].tick)) begin
                pos = i;
                break;
              end
            end
            backlog.insert(pos, e);
          end
        end
        CMD_DEQUEUE: begin
          if (backlog.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            e      = backlog.pop_front();
            r.irq  = e.code;
            r.prio = e.prio;
            r.tick = e.tick;
            handled_cnt++;
          end
        end
        CMD_SET_PANIC: panic = 1'b1;
        default:       panic = 1'b0;
      endcase
      r.pending = 5'(backlog.size());
      r.handled = handled_cnt;
      r.dropped = dropped_cnt;
      r.panic   = panic;
      awaited_words.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("result %0d: %s is %0h, expected %0h", result_index, what, got, want);
    endtask

    // Compare a returned word with the oldest expectation.
    task check_result(result_word_t got);
      result_word_t want;
      if (awaited_words.size() == 0) begin
        report("unexpected word, status", 32'(got.status), 0);
      end else begin
        want = awaited_words.pop_front();
        if (got.status !== want.status)
          report("status", 32'(got.status), 32'(want.status));
        if (got.irq !== want.irq)
          report("served_irq", 32'(got.irq), 32'(want.irq));
        if (got.prio !== want.prio)
          report("served_priority", 32'(got.prio), 32'(want.prio));
        if (got.tick    !== want.tick)    report("served_tick", got.tick, want.tick);
        if (got.pending !== want.pending)
          report("pending_count", 32'(got.pending), 32'(want.pending));
        if (got.handled !== want.handled) report("handled_total", got.handled, want.handled);
        if (got.dropped !== want.dropped) report("dropped_total", got.dropped, want.dropped);
        if (got.panic !== want.panic)
          report("panic_flag", 32'(got.panic), 32'(want.panic));
        if (got.pad     !== 1'b0)         report("pad bit", 32'(got.pad), 0);
      end
      result_index++;
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_BITS-1:0]    s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_BITS-1:0]   m_tdata;
  logic                  cfg_we;
  logic [TABLE_BITS-1:0] cfg_wdata;

  irq_queue_scoreboard board;
  bit                  send_idles;
  bit                  recv_idles;
  int                  quiet_cycles;

  interrupt_priority_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Clock generator.
  always begin
    clk = 1'b1;
    #HALF_PERIOD;
    clk = 1'b0;
    #HALF_PERIOD;
  end

  // Watchdog on cycles in which neither side moves a word.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("interrupt_priority_queue: mismatch");
        $finish;
      end
    end
  end

  function automatic int draw_gap(bit enabled);
    return enabled ? $urandom_range(0, MAX_IDLE) : 0;
  endfunction

  // Send one command word; returns at the falling edge after it was taken.
  task send_word(cmd_word_t w);
    int gap;
    gap = draw_gap(send_idles);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_command(w);
    @(negedge clk);
  endtask

  task issue(cmd_t c, int code, logic [TICK_BITS-1:0] tick);
    cmd_word_t w;
    w      = '0;
    w.cmd  = c;
    w.code = CODE_BITS'(code);
    w.tick = tick;
    send_word(w);
  endtask

  // Wait until every expected word has come back, with valid dropped.
  task wait_drained();
    s_tvalid <= 1'b0;
    while (board.awaited_words.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task write_table(logic [TABLE_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    board.set_table(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random command word; mode 0 fills, mode 1 drains, mode 2 mixes.
  function automatic cmd_word_t random_word(int mode);
    cmd_word_t w;
    int        roll;
    int        enq_pct;
    int        deq_pct;
    w = '0;
    case (mode)
      0:       begin enq_pct = 75; deq_pct = 20; end
      1:       begin enq_pct = 25; deq_pct = 70; end
      default: begin enq_pct = 48; deq_pct = 46; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < enq_pct)                 w.cmd = CMD_ENQUEUE;
    else if (roll < enq_pct + deq_pct)  w.cmd = CMD_DEQUEUE;
    else if ($urandom_range(0, 1) == 0) w.cmd = CMD_SET_PANIC;
    else                                w.cmd = CMD_CLEAR_PANIC;
    w.code = ($urandom_range(0, 9) == 0) ? CODE_BITS'($urandom_range(IRQ_KINDS, 7))
                                         : CODE_BITS'($urandom_range(0, IRQ_KINDS - 1));
    // Small stamps make equal keys common; the extremes show up too.
    roll = $urandom_range(0, 9);
    if (roll < 4)       w.tick = $urandom_range(0, 7);
    else if (roll == 4) w.tick = '0;
    else if (roll == 5) w.tick = '1;
    else                w.tick = $urandom();
    return w;
  endfunction

  // Receive side: random stalls, one check per accepted result word.
  initial begin
    int stall;
    m_tready = 1'b0;
    recv_idles = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (board.result_index % 50 == 0) recv_idles = ($urandom_range(0, 9) < 7);
      stall = draw_gap(recv_idles);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      board.check_result(m_tdata);
      @(negedge clk);
    end
  end

  // Main sequence: reset, directed cases, then random phases per table.
  initial begin
    logic [TABLE_BITS-1:0] tables[6];
    int                    mode;
    int                    p;
    int                    n;
    board        = new();
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    quiet_cycles = 0;
    send_idles   = 1'b1;
    tables[0] = 24'h000000;
    tables[1] = 24'hFFFFFF;
    tables[2] = 24'h012345;
    tables[3] = TABLE_BITS'($urandom());
    tables[4] = 24'h313131;
    tables[5] = TABLE_RESET;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // Empty dequeue and the panic commands.
    issue(CMD_DEQUEUE, 0, 0);
    issue(CMD_SET_PANIC, 7, '1);
    issue(CMD_CLEAR_PANIC, 0, 0);
    issue(CMD_SET_PANIC, 0, 0);
    // Extreme stamps, equal keys behind, a smaller stamp ahead.
    issue(CMD_ENQUEUE, 5, '1);
    issue(CMD_ENQUEUE, 0, '0);
    issue(CMD_ENQUEUE, 3, 100);
    issue(CMD_ENQUEUE, 3, 100);
    issue(CMD_ENQUEUE, 3, 99);
    // Invalid codes are rejected while there is room.
    issue(CMD_ENQUEUE, 6, 1);
    issue(CMD_ENQUEUE, 7, 2);
    issue(CMD_ENQUEUE, 1, $urandom());
    issue(CMD_ENQUEUE, 2, $urandom());
    issue(CMD_ENQUEUE, 4, $urandom());
    // Fill up, then drop on the full queue, also with an invalid code.
    for (n = 0; n < QUEUE_DEPTH - 8; n++)
      issue(CMD_ENQUEUE, $urandom_range(0, IRQ_KINDS - 1), $urandom_range(0, 3));
    issue(CMD_ENQUEUE, 2, 5);
    issue(CMD_ENQUEUE, 7, 6);
    issue(CMD_DEQUEUE, 0, 0);
    issue(CMD_DEQUEUE, 0, 0);
    issue(CMD_DEQUEUE, 0, 0);
    wait_drained();

    // Random bursts under each table; tables change only while idle.
    mode = 2;
    for (p = 0; p < 6; p++) begin
      write_table(tables[p]);
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (n % 40 == 0) mode = $urandom_range(0, 2);
        if (n % 50 == 0) send_idles = ($urandom_range(0, 9) < 7);
        send_word(random_word(mode));
      end
      wait_drained();
    end

    // Let any stray result word show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.awaited_words.size() == 0) begin
      $display("interrupt_priority_queue: match");
    end else begin
      $display("interrupt_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ipq_pkg.sv
rtl/ipq_ram.sv
rtl/interrupt_priority_queue.sv
rtl/ipq_checker.sv
tb/sv/tb_interrupt_priority_queue.sv
